>>> hw/rtl/present80_block_cipher_assert.svh
// ----------------------------------------------------------------------------
// PRESENT-80 assertion macros
// Shorthand for the concurrent assertions that the checker uses.
// ----------------------------------------------------------------------------
`ifndef PRESENT80_BLOCK_CIPHER_ASSERT_SVH
`define PRESENT80_BLOCK_CIPHER_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define PRS80_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("present80 assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define PRS80_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("present80 assertion failed");

`endif

>>> hw/rtl/prs80_pkg.sv
// ----------------------------------------------------------------------------
// PRESENT-80 package
// Widths, S-box tables, permutations, key schedule and datapath commands.
// ----------------------------------------------------------------------------
`default_nettype none

package prs80_pkg;

   localparam int DATA_W = 64;
   localparam int KEY_W  = 80;
   localparam int KEYH_W = 16;
   localparam int RND_W  = 5;

   typedef logic [DATA_W-1:0] block_type;
   typedef logic [KEY_W-1:0]  key_type;
   typedef logic [RND_W-1:0]  round_type;

   typedef enum logic [2:0] {
      OP_HOLD,
      OP_ENC_ROUND,
      OP_KEY_FWD,
      OP_KEY_FWD_XOR,
      OP_DEC_ROUND
   } dp_op_type;

   typedef struct packed {
      logic      load;
      dp_op_type op;
      logic      out_load;
      round_type round;
   } dp_cmd_type;

   function automatic logic [3:0] sbox_fwd(input logic [3:0] x);
      logic [3:0] y;
      case (x)
         4'h0: y = 4'hC;
         4'h1: y = 4'h5;
         4'h2: y = 4'h6;
         4'h3: y = 4'hB;
         4'h4: y = 4'h9;
         4'h5: y = 4'h0;
         4'h6: y = 4'hA;
         4'h7: y = 4'hD;
         4'h8: y = 4'h3;
         4'h9: y = 4'hE;
         4'hA: y = 4'hF;
         4'hB: y = 4'h8;
         4'hC: y = 4'h4;
         4'hD: y = 4'h7;
         4'hE: y = 4'h1;
         default: y = 4'h2;
      endcase
      return y;
   endfunction

   function automatic logic [3:0] sbox_inv(input logic [3:0] x);
      logic [3:0] y;
      case (x)
         4'h0: y = 4'h5;
         4'h1: y = 4'hE;
         4'h2: y = 4'hF;
         4'h3: y = 4'h8;
         4'h4: y = 4'hC;
         4'h5: y = 4'h1;
         4'h6: y = 4'h2;
         4'h7: y = 4'hD;
         4'h8: y = 4'hB;
         4'h9: y = 4'h4;
         4'hA: y = 4'h6;
         4'hB: y = 4'h3;
         4'hC: y = 4'h0;
         4'hD: y = 4'h7;
         4'hE: y = 4'h9;
         default: y = 4'hA;
      endcase
      return y;
   endfunction

   function automatic block_type sub_fwd(input block_type v);
      block_type r;
      for (int n = 0; n < DATA_W/4; n++) begin
         r[4*n +: 4] = sbox_fwd(v[4*n +: 4]);
      end
      return r;
   endfunction

   function automatic block_type sub_inv(input block_type v);
      block_type r;
      for (int n = 0; n < DATA_W/4; n++) begin
         r[4*n +: 4] = sbox_inv(v[4*n +: 4]);
      end
      return r;
   endfunction

   // Bit b moves to 16*(b mod 4) + b/4.
   function automatic block_type perm_fwd(input block_type v);
      block_type r;
      for (int b = 0; b < DATA_W; b++) begin
         r[16*(b & 3) + (b >> 2)] = v[b];
      end
      return r;
   endfunction

   function automatic block_type perm_inv(input block_type v);
      block_type r;
      for (int b = 0; b < DATA_W; b++) begin
         r[4*(b & 15) + (b >> 4)] = v[b];
      end
      return r;
   endfunction

   // One forward step of the key schedule with round counter i.
   function automatic key_type key_update(input key_type k, input round_type i);
      key_type t;
      t = {k[18:0], k[79:19]};
      t[79:76] = sbox_fwd(t[79:76]);
      t[19:15] = t[19:15] ^ i;
      return t;
   endfunction

   // Undoes key_update for the same round counter.
   function automatic key_type key_revert(input key_type k, input round_type i);
      key_type t;
      t = k;
      t[19:15] = t[19:15] ^ i;
      t[79:76] = sbox_inv(t[79:76]);
      return {t[60:0], t[79:61]};
   endfunction

endpackage

`default_nettype wire

>>> hw/rtl/prs80_req_if.sv
// ----------------------------------------------------------------------------
// PRESENT-80 request channel
// Valid/ready channel that carries one block, the key and the request type.
// ----------------------------------------------------------------------------
`default_nettype none

interface prs80_req_if
   import prs80_pkg::*;
();

   logic               valid;
   logic               ready;
   logic               req_type;
   logic [DATA_W-1:0]  data_in;
   logic [DATA_W-1:0]  key_low;
   logic [KEYH_W-1:0]  key_high;

   modport source (output valid, output req_type, output data_in, output key_low,
                   output key_high, input ready);
   modport sink (input valid, input req_type, input data_in, input key_low,
                 input key_high, output ready);
endinterface

`default_nettype wire

>>> hw/rtl/prs80_rsp_if.sv
// ----------------------------------------------------------------------------
// PRESENT-80 response channel
// Valid/ready channel that carries one output block.
// ----------------------------------------------------------------------------
`default_nettype none

interface prs80_rsp_if
   import prs80_pkg::*;
();

   logic              valid;
   logic              ready;
   logic [DATA_W-1:0] data_out;

   modport source (output valid, output data_out, input ready);
   modport sink (input valid, input data_out, output ready);
endinterface

`default_nettype wire

>>> hw/rtl/prs80_datapath.sv
// ----------------------------------------------------------------------------
// PRESENT-80 datapath
// State and key registers, one cipher round or key step per cycle, output
// register.
// ----------------------------------------------------------------------------
`default_nettype none

module prs80_datapath
   import prs80_pkg::*;
(
   input  wire logic              clock,
   input  wire dp_cmd_type        cmd,
   input  wire logic              req_type,
   input  wire logic [DATA_W-1:0] data_in,
   input  wire logic [DATA_W-1:0] key_low,
   input  wire logic [KEYH_W-1:0] key_high,
   output logic      [DATA_W-1:0] data_out
);

   block_type state_ff, state_in;
   key_type   key_ff, key_in;
   logic      mode_ff, mode_in;
   block_type out_ff, out_in;

   key_type   key_next;
   key_type   key_prev;

   always_comb begin
      key_next = key_update(key_ff, cmd.round);
      key_prev = key_revert(key_ff, cmd.round);

      state_in = state_ff;
      key_in   = key_ff;
      mode_in  = mode_ff;
      out_in   = out_ff;

      if (cmd.load) begin
         state_in = data_in;
         key_in   = {key_high, key_low};
         mode_in  = req_type;
      end else begin
         case (cmd.op)
            OP_ENC_ROUND: begin
               state_in = perm_fwd(sub_fwd(state_ff ^ key_ff[KEY_W-1:KEY_W-DATA_W]));
               key_in   = key_next;
            end
            OP_KEY_FWD: begin
               key_in = key_next;
            end
            OP_KEY_FWD_XOR: begin
               // Last forward step: whiten with the final round key.
               key_in   = key_next;
               state_in = state_ff ^ key_next[KEY_W-1:KEY_W-DATA_W];
            end
            OP_DEC_ROUND: begin
               state_in = sub_inv(perm_inv(state_ff)) ^ key_prev[KEY_W-1:KEY_W-DATA_W];
               key_in   = key_prev;
            end
            default: begin
            end
         endcase
      end

      if (cmd.out_load) begin
         out_in = mode_ff ? state_ff : (state_ff ^ key_ff[KEY_W-1:KEY_W-DATA_W]);
      end
   end

   always_ff @(posedge clock) begin
      state_ff <= state_in;
      key_ff   <= key_in;
      mode_ff  <= mode_in;
      out_ff   <= out_in;
   end

   assign data_out = out_ff;

endmodule

`default_nettype wire

>>> hw/rtl/prs80_ctrl.sv
// ----------------------------------------------------------------------------
// PRESENT-80 controller
// Sequences key roll-forward, rounds and output load; owns the handshakes.
// ----------------------------------------------------------------------------
`default_nettype none

module prs80_ctrl
   import prs80_pkg::*;
#(
   parameter int ROUND_COUNT = 31
) (
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic req_valid,
   input  wire logic req_type,
   output logic      req_ready,
   output logic      rsp_valid,
   input  wire logic rsp_ready,
   output dp_cmd_type cmd
);

   localparam logic [2:0] ST_IDLE   = 3'd0;
   localparam logic [2:0] ST_ENC    = 3'd1;
   localparam logic [2:0] ST_KEYFWD = 3'd2;
   localparam logic [2:0] ST_DEC    = 3'd3;
   localparam logic [2:0] ST_FIN    = 3'd4;

   localparam round_type LAST_ROUND  = RND_W'(ROUND_COUNT);
   localparam round_type FIRST_ROUND = RND_W'(1);

   logic [2:0] state_ff, state_in;
   round_type  cnt_ff, cnt_in;
   logic       ovalid_ff, ovalid_in;
   logic       accept;
   logic       out_free;

   assign req_ready = (state_ff == ST_IDLE);
   assign accept    = req_valid && req_ready;
   assign out_free  = !ovalid_ff || rsp_ready;
   assign rsp_valid = ovalid_ff;

   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      ovalid_in    = ovalid_ff && !rsp_ready;
      cmd.load     = 1'b0;
      cmd.op       = OP_HOLD;
      cmd.out_load = 1'b0;
      cmd.round    = cnt_ff;

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               cmd.load = 1'b1;
               cnt_in   = FIRST_ROUND;
               state_in = req_type ? ST_KEYFWD : ST_ENC;
            end
         end
         ST_ENC: begin
            cmd.op = OP_ENC_ROUND;
            if (cnt_ff == LAST_ROUND) begin
               state_in = ST_FIN;
            end else begin
               cnt_in = cnt_ff + FIRST_ROUND;
            end
         end
         ST_KEYFWD: begin
            if (cnt_ff == LAST_ROUND) begin
               cmd.op   = OP_KEY_FWD_XOR;
               state_in = ST_DEC;
            end else begin
               cmd.op = OP_KEY_FWD;
               cnt_in = cnt_ff + FIRST_ROUND;
            end
         end
         ST_DEC: begin
            cmd.op = OP_DEC_ROUND;
            if (cnt_ff == FIRST_ROUND) begin
               state_in = ST_FIN;
            end else begin
               cnt_in = cnt_ff - FIRST_ROUND;
            end
         end
         ST_FIN: begin
            if (out_free) begin
               cmd.out_load = 1'b1;
               ovalid_in    = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         cnt_ff    <= '0;
         ovalid_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         cnt_ff    <= cnt_in;
         ovalid_ff <= ovalid_in;
      end
   end

endmodule

`default_nettype wire

>>> hw/rtl/present80_block_cipher.sv
// ----------------------------------------------------------------------------
// PRESENT-80 block cipher: one round or key-schedule step per cycle.
// One transaction at a time: a new request is accepted only once the previous
// block has reached the output register; a stalled response holds the finished
// block until the output register frees up.
// Reset: synchronous, active high; clears the controller and the output valid.
// ----------------------------------------------------------------------------
`default_nettype none

// The block is split into a controller and a datapath. The datapath holds the
// 64-bit cipher state, the 80-bit key register and a separate output register,
// and performs one step per cycle on command: a forward round (key XOR, S-box
// layer, bit permutation plus a forward key-schedule step), a forward key step
// alone, or an inverse round that first reverts the key register by one step.
//
// Encryption runs ROUND_COUNT forward rounds and then loads the output register
// with the state XORed with the last round key. Decryption first rolls the key
// schedule forward ROUND_COUNT times, whitening the state with the last round
// key on the final step, then runs the inverse rounds while stepping the key
// schedule backward, so no round-key storage is needed.
//
// The output register is independent of the working registers, so a new
// transaction can be accepted while the previous result still waits on the
// response channel. The shared round unit allows one block in flight.

module present80_block_cipher
   import prs80_pkg::*;
#(
   parameter int ROUND_COUNT = 31
) (
   input  wire logic   clock,
   input  wire logic   reset,
   prs80_req_if.sink   req_if,
   prs80_rsp_if.source rsp_if
);

   dp_cmd_type cmd;

   prs80_ctrl #(
      .ROUND_COUNT (ROUND_COUNT)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_if.valid),
      .req_type  (req_if.req_type),
      .req_ready (req_if.ready),
      .rsp_valid (rsp_if.valid),
      .rsp_ready (rsp_if.ready),
      .cmd       (cmd)
   );

   prs80_datapath u_datapath (
      .clock    (clock),
      .cmd      (cmd),
      .req_type (req_if.req_type),
      .data_in  (req_if.data_in),
      .key_low  (req_if.key_low),
      .key_high (req_if.key_high),
      .data_out (rsp_if.data_out)
   );

endmodule

`default_nettype wire

>>> hw/rtl/prs80_chk.sv
// ----------------------------------------------------------------------------
// PRESENT-80 port checker
// Watches the top-level channels and is bound to every cipher instance.
// ----------------------------------------------------------------------------
`default_nettype none

`include "present80_block_cipher_assert.svh"

module prs80_chk
   import prs80_pkg::*;
(
   input wire logic              clock,
   input wire logic              reset,
   input wire logic              req_valid,
   input wire logic              req_ready,
   input wire logic              rsp_valid,
   input wire logic              rsp_ready,
   input wire logic [DATA_W-1:0] data_out
);

   logic [1:0] pend_ff, pend_in;
   logic       req_acc;
   logic       rsp_acc;

   assign req_acc = req_valid && req_ready;
   assign rsp_acc = rsp_valid && rsp_ready;

   // Transactions accepted but not yet answered.
   always_comb begin
      pend_in = pend_ff;
      if (req_acc && !rsp_acc) begin
         pend_in = pend_ff + 2'd1;
      end else if (!req_acc && rsp_acc) begin
         pend_in = pend_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff <= '0;
      end else begin
         pend_ff <= pend_in;
      end
   end

   `PRS80_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid)
   `PRS80_ASSERT_NEXT(a_rsp_stable, clock, reset, rsp_valid && !rsp_ready, $stable(data_out))
   `PRS80_ASSERT_SAME(a_rsp_has_req, clock, reset, rsp_valid, pend_ff != 2'd0)
   `PRS80_ASSERT_NEXT(a_one_in_flight, clock, reset, req_acc, !req_ready)

endmodule

bind present80_block_cipher prs80_chk u_prs80_chk (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_if.valid),
   .req_ready (req_if.ready),
   .rsp_valid (rsp_if.valid),
   .rsp_ready (rsp_if.ready),
   .data_out  (rsp_if.data_out)
);

`default_nettype wire
